### hw/rtl/rhht_pkg.sv
// rhht_pkg: shared codes and controller/datapath interface structs
// for the robin hood hash table unit; no dependencies
package rhht_pkg;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_CARRY,
      WR_SHIFT,
      WR_HOLE
   } wr_op_type;

   typedef enum logic [1:0] {
      VAL_ZERO,
      VAL_ROW,
      VAL_REQ
   } val_sel_type;

   typedef struct packed {
      logic        load;
      logic        idx_home;
      logic        idx_inc;
      logic        n_clr;
      logic        n_set1;
      logic        n_inc;
      logic        rd_en;
      logic        rd_next;
      wr_op_type   wr_op;
      logic        carry_init;
      logic        swap;
      logic        psl_inc;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        res_load;
      status_type  res_status;
      val_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic         row_valid;
      logic         key_match;
      logic         n_gt_psl;
      logic         carry_gt_psl;
      logic         row_psl_zero;
      logic         n_max;
      logic         n_end;
      logic         idx_last;
      logic         full;
      req_kind_type kind;
   } stat_type;

endpackage

### hw/rtl/rhht_datapath.sv
// rhht_datapath: bucket memory, probe counters, carried entry and result registers
// depends on rhht_pkg
module rhht_datapath #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rhht_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  rhht_pkg::cmd_type              cmd,
   output rhht_pkg::stat_type             stat,
   output logic [rhht_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rhht_pkg::*;

   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   typedef struct packed {
      logic          valid;
      logic [63:0]   key;
      logic [3:0]    len;
      logic [31:0]   hash;
      logic [AW-1:0] psl;
      logic [63:0]   value;
   } row_type;

   row_type mem [TABLE_SLOTS];
   row_type rd_row_ff;
   row_type carry_ff, carry_in;
   row_type wdata;

   logic [AW-1:0] idx_ff, idx_in, rd_addr;
   logic [AW:0]   n_ff, n_in;
   logic [AW:0]   count_ff, count_in;
   logic [63:0]   key_ff, val_ff, res_value_ff, sel_value;
   logic [3:0]    len_ff;
   logic [31:0]   hash_ff;
   req_kind_type  kind_ff;
   status_type    res_status_ff;
   logic [2:0]    rsp_status_ff;
   logic [63:0]   rsp_value_ff;

   logic [63:0] in_key, in_key_m;
   logic [3:0]  in_len, in_len_s;
   logic [31:0] in_hash;

   assign in_key  = req_tdata[63:0];
   assign in_len  = req_tdata[67:64];
   assign in_hash = req_tdata[99:68];
   assign in_len_s = (in_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_len;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         in_key_m[8*b +: 8] = (4'(b) < in_len_s) ? in_key[8*b +: 8] : 8'd0;
      end
   end

   assign rd_addr = cmd.rd_next ? idx_ff + AW'(1) : idx_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = in_hash[AW-1:0];
      end else if (cmd.idx_home) begin
         idx_in = hash_ff[AW-1:0];
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      n_in = n_ff;
      if (cmd.load || cmd.n_clr) begin
         n_in = '0;
      end else if (cmd.n_set1) begin
         n_in = (AW+1)'(1);
      end else if (cmd.n_inc) begin
         n_in = n_ff + (AW+1)'(1);
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (cmd.cnt_dec && count_ff != '0) begin
         count_in = count_ff - (AW+1)'(1);
      end
      carry_in = carry_ff;
      if (cmd.carry_init) begin
         carry_in = '{valid: 1'b1, key: key_ff, len: len_ff, hash: hash_ff,
                      psl: '0, value: val_ff};
      end else if (cmd.swap) begin
         carry_in = rd_row_ff;
      end
      if (cmd.psl_inc) begin
         carry_in.psl = carry_in.psl + AW'(1);
      end
      carry_in.valid = 1'b1;
   end

   always_comb begin
      wdata = carry_ff;
      case (cmd.wr_op)
         WR_SHIFT: begin
            wdata     = rd_row_ff;
            wdata.psl = rd_row_ff.psl - AW'(1);
         end
         WR_CLEAR, WR_HOLE: begin
            wdata       = rd_row_ff;
            wdata.valid = 1'b0;
         end
         default: wdata = carry_ff;
      endcase
   end

   always_comb begin
      case (cmd.res_sel)
         VAL_ROW: sel_value = rd_row_ff.value;
         VAL_REQ: sel_value = val_ff;
         default: sel_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_op != WR_NONE) begin
         mem[idx_ff] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         n_ff     <= '0;
         count_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      if (cmd.load) begin
         key_ff  <= in_key_m;
         len_ff  <= in_len_s;
         hash_ff <= in_hash;
         val_ff  <= req_tdata[163:100];
         kind_ff <= req_kind_type'(req_tuser);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= sel_value;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign stat.row_valid    = rd_row_ff.valid;
   assign stat.key_match    = rd_row_ff.hash == hash_ff && rd_row_ff.len == len_ff &&
                              rd_row_ff.key == key_ff;
   assign stat.n_gt_psl     = n_ff > {1'b0, rd_row_ff.psl};
   assign stat.carry_gt_psl = carry_ff.psl > rd_row_ff.psl;
   assign stat.row_psl_zero = rd_row_ff.psl == '0;
   assign stat.n_max        = n_ff == (AW+1)'(TABLE_SLOTS - 1);
   assign stat.n_end        = n_ff == (AW+1)'(TABLE_SLOTS);
   assign stat.idx_last     = idx_ff == AW'(TABLE_SLOTS - 1);
   assign stat.full         = count_ff == (AW+1)'(TABLE_SLOTS);
   assign stat.kind         = kind_ff;

   assign rsp_tdata = {5'd0, rsp_value_ff, rsp_status_ff};

endmodule

### hw/rtl/rhht_controller.sv
// rhht_controller: sequencer for clear pass, probe walk, insert carry and backward shift
// depends on rhht_pkg
module rhht_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rhht_pkg::stat_type  stat,
   output rhht_pkg::cmd_type   cmd
);
   import rhht_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FRD, S_FCHK, S_PRD, S_PCHK, S_DRD, S_DCHK, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = state_ff == S_IDLE;

   task automatic set_res(input status_type s, input val_sel_type v);
      cmd.res_load   = 1'b1;
      cmd.res_status = s;
      cmd.res_sel    = v;
   endtask

   always_comb begin
      cmd = '0;
      cmd.wr_op      = WR_NONE;
      cmd.res_status = ST_NOT_FOUND;
      cmd.res_sel    = VAL_ZERO;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_op   = WR_CLEAR;
            cmd.idx_inc = 1'b1;
            if (stat.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            if (stat.row_valid && stat.key_match) begin
               state_in = S_RESP;
               unique case (stat.kind)
                  REQ_LOOKUP: set_res(ST_FOUND, VAL_ROW);
                  REQ_INSERT: set_res(ST_DUPLICATE, VAL_ROW);
                  REQ_DELETE: begin
                     set_res(ST_FOUND, VAL_ROW);
                     cmd.cnt_dec = 1'b1;
                     cmd.n_set1  = 1'b1;
                     state_in    = S_DRD;
                  end
                  default: set_res(ST_NOT_FOUND, VAL_ZERO);
               endcase
            end else if (!stat.row_valid || stat.n_gt_psl || stat.n_max) begin
               state_in = S_RESP;
               if (stat.kind == REQ_INSERT) begin
                  if (stat.full) begin
                     set_res(ST_FULL, VAL_ZERO);
                  end else begin
                     cmd.carry_init = 1'b1;
                     cmd.idx_home   = 1'b1;
                     cmd.n_clr      = 1'b1;
                     state_in       = S_PRD;
                  end
               end else begin
                  set_res(ST_NOT_FOUND, VAL_ZERO);
               end
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.n_inc   = 1'b1;
               state_in    = S_FRD;
            end
         end
         S_PRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_PCHK;
         end
         S_PCHK: begin
            if (!stat.row_valid) begin
               cmd.wr_op   = WR_CARRY;
               cmd.cnt_inc = 1'b1;
               set_res(ST_INSERTED, VAL_REQ);
               state_in = S_RESP;
            end else begin
               if (stat.carry_gt_psl) begin
                  cmd.wr_op = WR_CARRY;
                  cmd.swap  = 1'b1;
               end
               cmd.psl_inc = 1'b1;
               cmd.idx_inc = 1'b1;
               cmd.n_inc   = 1'b1;
               if (stat.n_max) begin
                  set_res(ST_INSERTED, VAL_REQ);
                  state_in = S_RESP;
               end else begin
                  state_in = S_PRD;
               end
            end
         end
         S_DRD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_DCHK;
         end
         S_DCHK: begin
            if (stat.n_end || !stat.row_valid || stat.row_psl_zero) begin
               cmd.wr_op = WR_HOLE;
               state_in  = S_RESP;
            end else begin
               cmd.wr_op   = WR_SHIFT;
               cmd.idx_inc = 1'b1;
               cmd.n_inc   = 1'b1;
               state_in    = S_DRD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### hw/rtl/robin_hood_hash_table_unit.sv
// robin_hood_hash_table_unit: top level of the robin hood hash table
// depends on rhht_pkg, rhht_controller, rhht_datapath
//
// usage: one request transaction on req_* gives exactly one response on rsp_*.
// req_tuser is the request kind (lookup, insert, delete); req_tdata carries the
// key, key length, upstream hash and insert value. rsp_tdata carries status and
// the value found, inserted or removed.
// after reset the bucket memory is swept once, one bucket a cycle, and req_tready
// stays low until the sweep is through and the first request can be taken.
// one request is worked at a time: idle takes it, each probed bucket is read
// (S_FRD) and checked (S_FCHK), each bucket of the insert carry walk (S_PRD, S_PCHK)
// or of the delete shift chain (S_DRD, S_DCHK, the last bucket included) likewise,
// and S_RESP loads the response register, with rsp_tvalid rising as it is loaded.
// a stalled rsp_tready holds the response; the next request is taken while the
// previous response still waits, and its own response waits behind it.
module robin_hood_hash_table_unit #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key_bytes[63:0], key_length[67:64], key_hash[99:68], new_value[163:100]
   input  logic [rhht_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], result_value[66:3]
   output logic [rhht_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rhht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rhht_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rhht_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BYTES   (KEY_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for robin_hood_hash_table_unit
// depends on rhht_pkg and the unit rtl; holds its own bucket model and scoreboard
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rhht_pkg::*;

   localparam int SLOTS = 1024;
   localparam int KB = 8;
   localparam int IDLE_LIMIT = 20000;

   class hash_scoreboard;
      bit          b_valid [SLOTS];
      logic [63:0] b_key   [SLOTS];
      logic [31:0] b_hash  [SLOTS];
      logic [3:0]  b_len   [SLOTS];
      int          b_psl   [SLOTS];
      logic [63:0] b_val   [SLOTS];
      int          count;
      logic [2:0]  want_status [$];
      logic [63:0] want_value  [$];
      int          mismatches;

      function void clear();
         foreach (b_valid[i]) b_valid[i] = 0;
         count = 0;
         mismatches = 0;
      endfunction

      function bit locate(logic [63:0] k, logic [3:0] l, logic [31:0] h, output int at);
         int i;
         i = h & (SLOTS - 1);
         at = 0;
         for (int n = 0; n < SLOTS; n++) begin
            if (!b_valid[i]) return 0;
            if (b_hash[i] == h && b_len[i] == l && b_key[i] == k) begin
               at = i;
               return 1;
            end
            if (n > b_psl[i]) return 0;
            i = (i + 1) & (SLOTS - 1);
         end
         return 0;
      endfunction

      function void place(logic [63:0] k, logic [3:0] l, logic [31:0] h, logic [63:0] v);
         int i, p, tp;
         logic [63:0] tk, tv;
         logic [3:0] tl;
         logic [31:0] th;
         i = h & (SLOTS - 1);
         p = 0;
         for (int n = 0; n < SLOTS; n++) begin
            if (!b_valid[i]) begin
               b_valid[i] = 1; b_key[i] = k; b_len[i] = l; b_hash[i] = h;
               b_val[i] = v; b_psl[i] = p; count++;
               return;
            end
            if (p > b_psl[i]) begin
               tk = b_key[i]; tv = b_val[i]; tl = b_len[i]; th = b_hash[i]; tp = b_psl[i];
               b_key[i] = k; b_val[i] = v; b_len[i] = l; b_hash[i] = h; b_psl[i] = p;
               k = tk; v = tv; l = tl; h = th; p = tp;
            end
            p++;
            i = (i + 1) & (SLOTS - 1);
         end
      endfunction

      function void remove(int i);
         int nx;
         b_valid[i] = 0;
         if (count > 0) count--;
         for (int n = 1; n < SLOTS; n++) begin
            nx = (i + 1) & (SLOTS - 1);
            if (!b_valid[nx] || b_psl[nx] == 0) return;
            b_valid[i] = 1; b_key[i] = b_key[nx]; b_len[i] = b_len[nx];
            b_hash[i] = b_hash[nx]; b_val[i] = b_val[nx]; b_psl[i] = b_psl[nx] - 1;
            b_valid[nx] = 0;
            i = nx;
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [63:0] kraw, logic [3:0] lraw,
                                 logic [31:0] h, logic [63:0] v);
         logic [3:0] l;
         logic [63:0] k;
         logic [2:0] st;
         logic [63:0] rv;
         int at;
         l = (lraw > KB) ? 4'(KB) : lraw;
         k = (l >= 8) ? kraw : (kraw & ((64'd1 << (8 * l)) - 64'd1));
         st = ST_NOT_FOUND;
         rv = '0;
         case (kind)
            REQ_LOOKUP: if (locate(k, l, h, at)) begin
               st = ST_FOUND; rv = b_val[at];
            end
            REQ_INSERT: if (locate(k, l, h, at)) begin
               st = ST_DUPLICATE; rv = b_val[at];
            end else if (count >= SLOTS) begin
               st = ST_FULL;
            end else begin
               place(k, l, h, v); st = ST_INSERTED; rv = v;
            end
            REQ_DELETE: if (locate(k, l, h, at)) begin
               st = ST_FOUND; rv = b_val[at]; remove(at);
            end
            default: ;
         endcase
         want_status.push_back(st);
         want_value.push_back(rv);
      endfunction

      function void check_response(logic [2:0] st, logic [63:0] rv);
         if (want_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status=%0d value=%h", st, rv);
            return;
         end
         if (want_status[0] !== st || want_value[0] !== rv) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                        want_status[0], want_value[0], st, rv);
         end
         void'(want_status.pop_front());
         void'(want_value.pop_front());
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   hash_scoreboard sb = new();
   int idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   robin_hood_hash_table_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // accepted transactions, sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[63:0], req_tdata[67:64],
                            req_tdata[99:68], req_tdata[163:100]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[2:0], rsp_tdata[66:3]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > IDLE_LIMIT + 2 * SLOTS) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if (($urandom % 200) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom % 4) != 0;
         2: rsp_tready <= ($urandom % 4) == 0;
         default: rsp_tready <= ($urandom % 16) < 12;
      endcase
   end

   int burst_left = 0;

   task automatic send_request(logic [1:0] kind, logic [63:0] k, logic [3:0] l,
                               logic [31:0] h, logic [63:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, v, h, l, k};
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) req_tvalid <= 1'b0;
   endtask

   typedef struct {
      logic [63:0] k;
      logic [3:0]  l;
      logic [31:0] h;
   } key_rec_type;
   key_rec_type pool [$];

   function automatic key_rec_type fresh_key();
      key_rec_type r;
      r.k = {$urandom, $urandom};
      r.l = 4'($urandom_range(1, 8));
      if ($urandom % 4 == 0) r.h = {22'($urandom), 6'd0, 4'($urandom_range(0, 3))};
      else r.h = $urandom;
      r.k = (r.l >= 8) ? r.k : (r.k & ((64'd1 << (8 * r.l)) - 64'd1));
      return r;
   endfunction

   initial begin
      key_rec_type r;
      int pick;
      logic [1:0] kind;
      logic [63:0] kk;
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_request(REQ_LOOKUP, 64'h0, 4'd1, 32'h0, 64'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 64'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 64'h1234);
      send_request(REQ_INSERT, 64'hAB, 4'd1, 32'h5, 64'h11);
      send_request(REQ_INSERT, 64'hFFAB, 4'd1, 32'h5, 64'h22);
      send_request(REQ_INSERT, 64'hCD, 4'd1, 32'h5, 64'h33);
      send_request(REQ_INSERT, 64'h0, 4'd0, 32'h5, 64'h44);
      send_request(REQ_LOOKUP, 64'hFF, 4'd0, 32'h5, 64'h0);
      send_request(REQ_INSERT, 64'h77, 4'd2, 32'h6, 64'h55);
      send_request(REQ_INSERT, 64'h88, 4'd2, 32'h4, 64'h66);
      send_request(REQ_NONE, 64'hAB, 4'd1, 32'h5, 64'h0);
      send_request(REQ_DELETE, 64'hAB, 4'd1, 32'h5, 64'h0);
      send_request(REQ_DELETE, 64'hAB, 4'd1, 32'h5, 64'h0);
      send_request(REQ_LOOKUP, 64'hCD, 4'd1, 32'h5, 64'h0);
      send_request(REQ_LOOKUP, 64'h77, 4'd2, 32'h6, 64'h0);
      send_request(REQ_DELETE, 64'h0, 4'd0, 32'h5, 64'h0);
      send_request(REQ_LOOKUP, 64'h88, 4'd2, 32'h4, 64'h0);
      send_request(REQ_INSERT, 64'h99, 4'd3, 32'h3FF, 64'h77);
      send_request(REQ_INSERT, 64'hAA, 4'd3, 32'h3FF, 64'h88);
      send_request(REQ_LOOKUP, 64'hAA, 4'd3, 32'h3FF, 64'h0);

      // random part: keys from a live pool
      for (int n = 0; n < 750; n++) begin
         if (pool.size() == 0 || $urandom % 3 == 0) begin
            r = fresh_key();
            pool.push_back(r);
            if (pool.size() > 200) pool.delete(0);
         end
         pick = $urandom_range(0, pool.size() - 1);
         r = pool[pick];
         case ($urandom % 20)
            0, 1, 2, 3, 4, 5, 6, 7: kind = REQ_INSERT;
            8, 9, 10, 11, 12: kind = REQ_LOOKUP;
            13, 14, 15, 16, 17: kind = REQ_DELETE;
            18: kind = REQ_NONE;
            default: kind = 2'($urandom);
         endcase
         kk = r.k;
         if ($urandom % 8 == 0 && r.l < 8) kk = kk | ({$urandom, $urandom} << (8 * r.l));
         if ($urandom % 16 == 0) r = fresh_key();
         send_request(kind, kk, ($urandom % 20 == 0 && r.l == 8) ? 4'($urandom_range(9, 15)) : r.l,
                      r.h, {$urandom, $urandom});
      end

      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 64'h0);
      send_request(REQ_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 64'h0);
      send_request(REQ_INSERT, 64'h5, 4'd1, 32'h1, 64'h5);
      req_tvalid <= 1'b0;

      while (sb.want_status.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.want_status.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### files.f
hw/rtl/rhht_pkg.sv
hw/rtl/rhht_datapath.sv
hw/rtl/rhht_controller.sv
hw/rtl/robin_hood_hash_table_unit.sv
bench/tb_top.sv
